@@ hw/rtl/bmsi_pkg.sv @@
// Shared types, codes and helpers of the bank mapper with scanline interrupt.
package bmsi_pkg;

    // Op codes of the request channel
    localparam logic [2:0] OP_CPU_RD = 3'd0;
    localparam logic [2:0] OP_CPU_WR = 3'd1;
    localparam logic [2:0] OP_PPU_RD = 3'd2;
    localparam logic [2:0] OP_PPU_WR = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    // Target kinds of the result channel
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PRG_RAM = 2'd1;
    localparam logic [1:0] KIND_PRG_ROM = 2'd2;
    localparam logic [1:0] KIND_CHR_ROM = 2'd3;

    // Mapper register windows, picked by cpu address bits 14:13
    localparam logic [1:0] WIN_BANK   = 2'd0;
    localparam logic [1:0] WIN_MIRROR = 2'd1;
    localparam logic [1:0] WIN_LATCH  = 2'd2;
    localparam logic [1:0] WIN_ENABLE = 2'd3;

    // Configuration register indexes, from paddr bit 2
    localparam logic REG_PRG_CNT = 1'b0;
    localparam logic REG_CHR_CNT = 1'b1;

    localparam logic [5:0] PRG_CNT_RESET = 6'd2;
    localparam logic [5:0] CHR_CNT_RESET = 6'd1;

    // Configured bank counts
    typedef struct packed {
        logic [5:0] prg_cnt;
        logic [5:0] chr_cnt;
    } t_cfg;

    // Request to the shared modulo unit
    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [8:0] divisor;
    } t_mod_req;

    // Answer of the shared modulo unit
    typedef struct packed {
        logic       done;
        logic [7:0] rem;
    } t_mod_rsp;

    // Zero counts as one, anything above 32 as 32
    function automatic logic [5:0] clamp_count(input logic [5:0] c);
        logic [5:0] r;
        priority if (c == 6'd0) begin
            r = 6'd1;
        end else if (c > 6'd32) begin
            r = 6'd32;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/bmsi_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface bmsi_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [15:0] addr;
    logic [7:0] data;

    modport source (output valid, op, addr, data, input ready);
    modport sink   (input valid, op, addr, data, output ready);
endinterface

interface bmsi_rsp_if;
    logic        valid;
    logic        ready;
    logic [18:0] map_offset;
    logic [1:0]  target_kind;
    logic        irq_line;
    logic        mirror_horizontal;

    modport source (output valid, map_offset, target_kind, irq_line, mirror_horizontal,
                    input ready);
    modport sink   (input valid, map_offset, target_kind, irq_line, mirror_horizontal,
                    output ready);
endinterface

@@ hw/rtl/bmsi_mod_unit.sv @@
// Shared restoring modulo unit: 8-bit dividend, one quotient bit per cycle.
module bmsi_mod_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bmsi_pkg::t_mod_req  i_req,
    output bmsi_pkg::t_mod_rsp  o_rsp
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_div;
    logic [8:0] r_dsr;
    logic [7:0] r_rem;

    logic [8:0] trial;
    logic [8:0] diff;
    logic [7:0] n_rem;

    // One shift-subtract step
    always_comb begin
        trial = {r_rem, r_div[7]};
        diff  = trial - r_dsr;
        if (trial >= r_dsr) begin
            n_rem = diff[7:0];
        end else begin
            n_rem = trial[7:0];
        end
    end

    // Step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            // done pulses once after the last step
            r_done <= !i_req.start && r_busy && (r_cnt == 3'd7);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_div  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= 8'd0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_div <= {r_div[6:0], 1'b0};
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

@@ hw/rtl/bmsi_core.sv @@
// Mapper state, address translation, irq counter and slot sequencer.
module bmsi_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bmsi_req_if.sink            i_req,
    bmsi_rsp_if.source          o_rsp,
    input  bmsi_pkg::t_cfg      i_cfg,
    output bmsi_pkg::t_mod_req  o_mod_req,
    input  bmsi_pkg::t_mod_rsp  i_mod_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MOD, S_DONE} t_state;

    t_state      r_state;
    logic [2:0]  r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    logic [7:0]  r_bank [8];
    logic [2:0]  r_sel;
    logic        r_prg_mode;
    logic        r_chr_inv;
    logic [7:0]  r_chr_slot [8];
    logic [5:0]  r_prg_slot [4];
    logic        r_mirror;
    logic [7:0]  r_irq_reload;
    logic [7:0]  r_irq_count;
    logic        r_irq_en;
    logic        r_irq_pend;

    logic [2:0]  r_idx;
    logic        r_mod_start;

    logic        r_out_valid;
    logic [18:0] r_out_addr;
    logic [1:0]  r_out_kind;
    logic        r_out_irq;
    logic        r_out_mirror;

    logic        out_free;
    logic        out_load;
    logic        mod_kick;
    logic [5:0]  prg_cnt;
    logic [5:0]  chr_cnt;
    logic [6:0]  prg_8k;
    logic [5:0]  prg_last_m1;
    logic [5:0]  prg_last;
    logic [2:0]  slot1k;
    logic [7:0]  pair;

    logic [18:0] n_addr;
    logic [1:0]  n_kind;
    logic        n_bank_wr;
    logic [2:0]  n_sel;
    logic        n_prg_mode;
    logic        n_chr_inv;
    logic        n_mirror;
    logic [7:0]  n_irq_reload;
    logic [7:0]  n_irq_count;
    logic        n_irq_en;
    logic        n_irq_pend;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Result register load and modulo start for the current step
    assign out_load = out_free && (((r_state == S_EXEC) && !n_bank_wr) ||
                                   (r_state == S_DONE));
    assign mod_kick = ((r_state == S_EXEC) && n_bank_wr) ||
                      ((r_state == S_MOD) && i_mod_rsp.done && (r_idx != 3'd7));

    // Bank counts in 8K program and 1K video units
    assign prg_cnt     = bmsi_pkg::clamp_count(i_cfg.prg_cnt);
    assign chr_cnt     = bmsi_pkg::clamp_count(i_cfg.chr_cnt);
    assign prg_8k      = {prg_cnt, 1'b0};
    assign prg_last_m1 = 6'(prg_8k - 7'd2);
    assign prg_last    = 6'(prg_8k - 7'd1);
    assign slot1k      = r_idx - 3'd2;
    assign pair        = {i_mod_rsp.rem[7:1], 1'b0};

    // Modulo requests: banks 0..5 by the video count, 6..7 by the program count
    assign o_mod_req.start    = r_mod_start;
    assign o_mod_req.dividend = r_bank[r_idx];
    assign o_mod_req.divisor  = (r_idx[2:1] == 2'b11) ? {2'b00, prg_8k}
                                                      : {chr_cnt, 3'b000};

    // Effect and answer of the held item
    always_comb begin
        n_addr       = 19'd0;
        n_kind       = bmsi_pkg::KIND_NONE;
        n_bank_wr    = 1'b0;
        n_sel        = r_sel;
        n_prg_mode   = r_prg_mode;
        n_chr_inv    = r_chr_inv;
        n_mirror     = r_mirror;
        n_irq_reload = r_irq_reload;
        n_irq_count  = r_irq_count;
        n_irq_en     = r_irq_en;
        n_irq_pend   = r_irq_pend;
        unique case (r_op)
            bmsi_pkg::OP_CPU_RD, bmsi_pkg::OP_CPU_WR: begin
                if (r_addr[15:13] == 3'b011) begin
                    n_addr = {6'd0, r_addr[12:0]};
                    n_kind = bmsi_pkg::KIND_PRG_RAM;
                end else if (r_addr[15] && (r_op == bmsi_pkg::OP_CPU_RD)) begin
                    n_addr = {r_prg_slot[r_addr[14:13]], r_addr[12:0]};
                    n_kind = bmsi_pkg::KIND_PRG_ROM;
                end else if (r_addr[15]) begin
                    unique case (r_addr[14:13])
                        bmsi_pkg::WIN_BANK: begin
                            if (r_addr[0]) begin
                                n_bank_wr = 1'b1;
                            end else begin
                                n_sel      = r_data[2:0];
                                n_prg_mode = r_data[6];
                                n_chr_inv  = r_data[7];
                            end
                        end
                        bmsi_pkg::WIN_MIRROR: begin
                            if (!r_addr[0]) begin
                                n_mirror = r_data[0];
                            end
                        end
                        bmsi_pkg::WIN_LATCH: begin
                            if (r_addr[0]) begin
                                n_irq_count = 8'd0;
                            end else begin
                                n_irq_reload = r_data;
                            end
                        end
                        bmsi_pkg::WIN_ENABLE: begin
                            if (r_addr[0]) begin
                                n_irq_en = 1'b1;
                            end else begin
                                n_irq_en   = 1'b0;
                                n_irq_pend = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bmsi_pkg::OP_PPU_RD: begin
                if (r_addr[15:13] == 3'b000) begin
                    n_addr = {1'b0, r_chr_slot[r_addr[12:10]], r_addr[9:0]};
                    n_kind = bmsi_pkg::KIND_CHR_ROM;
                end
            end
            bmsi_pkg::OP_TICK: begin
                if (r_irq_count == 8'd0) begin
                    n_irq_count = r_irq_reload;
                end else begin
                    n_irq_count = r_irq_count - 8'd1;
                end
                if ((n_irq_count == 8'd0) && r_irq_en) begin
                    n_irq_pend = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Sequencer, mapper state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= 3'd0;
            r_mod_start   <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_bank[i]     <= 8'd0;
                r_chr_slot[i] <= 8'd0;
            end
            r_prg_slot[0] <= 6'd0;
            r_prg_slot[1] <= 6'd1;
            r_prg_slot[2] <= 6'({bmsi_pkg::PRG_CNT_RESET, 1'b0} - 7'd2);
            r_prg_slot[3] <= 6'({bmsi_pkg::PRG_CNT_RESET, 1'b0} - 7'd1);
            r_sel         <= 3'd0;
            r_prg_mode    <= 1'b0;
            r_chr_inv     <= 1'b0;
            r_mirror      <= 1'b1;
            r_irq_reload  <= 8'd0;
            r_irq_count   <= 8'd0;
            r_irq_en      <= 1'b0;
            r_irq_pend    <= 1'b0;
        end else begin
            r_mod_start <= mod_kick;
            r_out_valid <= (r_out_valid && !o_rsp.ready) || out_load;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.op;
                        r_addr  <= i_req.addr;
                        r_data  <= i_req.data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (n_bank_wr) begin
                        r_bank[r_sel] <= r_data;
                        r_idx         <= 3'd0;
                        r_state       <= S_MOD;
                    end else if (out_free) begin
                        r_sel        <= n_sel;
                        r_prg_mode   <= n_prg_mode;
                        r_chr_inv    <= n_chr_inv;
                        r_mirror     <= n_mirror;
                        r_irq_reload <= n_irq_reload;
                        r_irq_count  <= n_irq_count;
                        r_irq_en     <= n_irq_en;
                        r_irq_pend   <= n_irq_pend;
                        r_out_addr   <= n_addr;
                        r_out_kind   <= n_kind;
                        r_out_irq    <= n_irq_pend;
                        r_out_mirror <= n_mirror;
                        r_state      <= S_IDLE;
                    end
                end
                S_MOD: begin
                    if (i_mod_rsp.done) begin
                        // Place the remainder of bank r_idx into its slots
                        unique case (r_idx)
                            3'd0: begin
                                r_chr_slot[{r_chr_inv, 2'b00}] <= pair;
                                r_chr_slot[{r_chr_inv, 2'b01}] <= pair + 8'd1;
                            end
                            3'd1: begin
                                r_chr_slot[{r_chr_inv, 2'b10}] <= pair;
                                r_chr_slot[{r_chr_inv, 2'b11}] <= pair + 8'd1;
                            end
                            3'd2, 3'd3, 3'd4, 3'd5: begin
                                r_chr_slot[{!r_chr_inv, slot1k[1:0]}] <= i_mod_rsp.rem;
                            end
                            3'd6: begin
                                if (r_prg_mode) begin
                                    r_prg_slot[0] <= i_mod_rsp.rem[5:0];
                                    r_prg_slot[2] <= prg_last_m1;
                                end else begin
                                    r_prg_slot[0] <= prg_last_m1;
                                    r_prg_slot[2] <= i_mod_rsp.rem[5:0];
                                end
                            end
                            3'd7: begin
                                r_prg_slot[1] <= i_mod_rsp.rem[5:0];
                                r_prg_slot[3] <= prg_last;
                            end
                            default: ;
                        endcase
                        if (r_idx == 3'd7) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_addr   <= 19'd0;
                        r_out_kind   <= bmsi_pkg::KIND_NONE;
                        r_out_irq    <= r_irq_pend;
                        r_out_mirror <= r_mirror;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.map_offset        = r_out_addr;
    assign o_rsp.target_kind       = r_out_kind;
    assign o_rsp.irq_line          = r_out_irq;
    assign o_rsp.mirror_horizontal = r_out_mirror;

    // A finished remainder only arrives while the slot sweep runs
    a_done_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mod_rsp.done |-> (r_state == S_MOD))
        else $error("modulo result outside slot sweep");

    // An accepted beat is worked on in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

    // The end of a sweep answers with no target
    a_sweep_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=>
        (r_out_valid && (r_out_kind == bmsi_pkg::KIND_NONE)))
        else $error("bank write result missing");

endmodule

@@ hw/rtl/bank_mapper_with_scanline_irq.sv @@
// Top level: bank count registers on the APB port, mapper core and modulo unit.
//
//  channel   dir   handshake             beat
//  i_req     in    valid/ready           op, addr, data
//  o_rsp     out   valid/ready           map_offset, target_kind, irq_line,
//                                        mirror_horizontal
//  apb       in    psel/penable/pwrite   paddr, pwdata -> prdata, pready
//
// One beat at a time. Reads, plain register writes and ticks load the result in the
// execute step after accept, and the next beat is taken once that step is done. A
// bank-data write sweeps all eight banks through the shared modulo unit in turn and
// loads its result in the sweep-end step. The result register lets the next beat in
// while a result waits; a stalled output holds only the execute or sweep-end step.
// Reset is synchronous and active low and restores all but held beat and result data.
module bank_mapper_with_scanline_irq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmsi_req_if.sink    i_req,
    bmsi_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]          r_prg_cnt;
    logic [5:0]          r_chr_cnt;
    logic                apb_wr;
    bmsi_pkg::t_cfg      cfg;
    bmsi_pkg::t_mod_req  mod_req;
    bmsi_pkg::t_mod_rsp  mod_rsp;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    // Bank count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_cnt <= bmsi_pkg::PRG_CNT_RESET;
            r_chr_cnt <= bmsi_pkg::CHR_CNT_RESET;
        end else if (apb_wr) begin
            unique case (paddr[2])
                bmsi_pkg::REG_PRG_CNT: r_prg_cnt <= pwdata[5:0];
                bmsi_pkg::REG_CHR_CNT: r_chr_cnt <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            bmsi_pkg::REG_PRG_CNT: prdata = {26'd0, r_prg_cnt};
            bmsi_pkg::REG_CHR_CNT: prdata = {26'd0, r_chr_cnt};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg.prg_cnt = r_prg_cnt;
    assign cfg.chr_cnt = r_chr_cnt;

    bmsi_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    bmsi_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_cfg     (cfg),
        .o_mod_req (mod_req),
        .i_mod_rsp (mod_rsp)
    );

endmodule

@@ bench/bank_mapper_with_scanline_irq_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the bank mapper: directed table, then random beats.
module bank_mapper_with_scanline_irq_tb;

    // Op codes past the defined set, which the mapper must ignore
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int MAX_WAIT        = 6;
    localparam int NUM_PHASES      = 8;
    localparam int BEATS_PER_PHASE = 135;
    localparam int SETTLE_CYCLES   = 100;
    localparam int IDLE_LIMIT      = 2000;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_access;

    typedef struct packed {
        logic [18:0] map_offset;
        logic [1:0]  target_kind;
        logic        irq_line;
        logic        mirror_horizontal;
    } t_mapping;

    typedef struct packed {
        t_access  acc;
        logic     typed;
        t_mapping want;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bmsi_req_if req_ch ();
    bmsi_rsp_if rsp_ch ();

    bank_mapper_with_scanline_irq dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Mapper state as the bench expects it
    logic [5:0] cfg_prg;
    logic [5:0] cfg_chr;
    logic [7:0] bank_regs [8];
    logic [2:0] bank_sel;
    logic       prg_swap;
    logic       chr_swap;
    logic [7:0] chr_slot [8];
    logic [5:0] prg_slot [4];
    logic       mirror_h;
    logic [7:0] irq_reload;
    logic [7:0] irq_down;
    logic       irq_armed;
    logic       irq_flag;

    t_mapping mapping_q [$];
    t_row     stim_table [$];
    int       mismatches = 0;
    int       stall_cycles = 0;
    logic     steady = 1'b0;

    // Apply one access to the expected state and return the mapping it yields
    function automatic t_mapping map_access(input t_access a);
        t_mapping    m;
        int unsigned p;
        int unsigned v;
        int unsigned pair0;
        int unsigned pair1;
        int unsigned b2;
        int unsigned b1;
        int unsigned sw;
        int unsigned i;
        m = '0;
        case (a.op)
            bmsi_pkg::OP_CPU_RD, bmsi_pkg::OP_CPU_WR: begin
                if (a.addr >= 16'h6000 && a.addr <= 16'h7FFF) begin
                    m.map_offset  = 19'(a.addr[12:0]);
                    m.target_kind = bmsi_pkg::KIND_PRG_RAM;
                end else if (a.addr[15]) begin
                    if (a.op == bmsi_pkg::OP_CPU_RD) begin
                        m.map_offset  = {prg_slot[a.addr[14:13]], a.addr[12:0]};
                        m.target_kind = bmsi_pkg::KIND_PRG_ROM;
                    end else begin
                        case (a.addr[14:13])
                            bmsi_pkg::WIN_BANK: begin
                                if (!a.addr[0]) begin
                                    bank_sel = a.data[2:0];
                                    prg_swap = a.data[6];
                                    chr_swap = a.data[7];
                                end else begin
                                    bank_regs[bank_sel] = a.data;
                                    // counts clamp to 1..32, then in 8K / 1K units
                                    p = (cfg_prg == 0) ? 1 : (cfg_prg > 32) ? 32 : cfg_prg;
                                    v = (cfg_chr == 0) ? 1 : (cfg_chr > 32) ? 32 : cfg_chr;
                                    p = p * 2;
                                    v = v * 8;
                                    pair0 = (bank_regs[0] % v) & 'hFE;
                                    pair1 = (bank_regs[1] % v) & 'hFE;
                                    b2 = chr_swap ? 4 : 0;
                                    b1 = chr_swap ? 0 : 4;
                                    chr_slot[b2]     = 8'(pair0);
                                    chr_slot[b2 + 1] = 8'(pair0 + 1);
                                    chr_slot[b2 + 2] = 8'(pair1);
                                    chr_slot[b2 + 3] = 8'(pair1 + 1);
                                    for (i = 0; i < 4; i++) begin
                                        chr_slot[b1 + i] = 8'(bank_regs[2 + i] % v);
                                    end
                                    sw = (bank_regs[6] % p) & 'h3F;
                                    prg_slot[0] = prg_swap ? 6'(sw) : 6'(p - 2);
                                    prg_slot[2] = prg_swap ? 6'(p - 2) : 6'(sw);
                                    prg_slot[1] = 6'(bank_regs[7] % p);
                                    prg_slot[3] = 6'(p - 1);
                                end
                            end
                            bmsi_pkg::WIN_MIRROR: begin
                                if (!a.addr[0]) begin
                                    mirror_h = a.data[0];
                                end
                            end
                            bmsi_pkg::WIN_LATCH: begin
                                if (!a.addr[0]) begin
                                    irq_reload = a.data;
                                end else begin
                                    irq_down = '0;
                                end
                            end
                            default: begin
                                if (!a.addr[0]) begin
                                    irq_armed = 1'b0;
                                    irq_flag = 1'b0;
                                end else begin
                                    irq_armed = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            bmsi_pkg::OP_PPU_RD: begin
                if (a.addr < 16'h2000) begin
                    m.map_offset  = 19'({chr_slot[a.addr[12:10]], a.addr[9:0]});
                    m.target_kind = bmsi_pkg::KIND_CHR_ROM;
                end
            end
            bmsi_pkg::OP_TICK: begin
                if (irq_down == 0) begin
                    irq_down = irq_reload;
                end else begin
                    irq_down = irq_down - 8'd1;
                end
                if (irq_down == 0 && irq_armed) begin
                    irq_flag = 1'b1;
                end
            end
            default: ;
        endcase
        m.irq_line = irq_flag;
        m.mirror_horizontal = mirror_h;
        return m;
    endfunction

    function automatic t_row row_typed(input logic [2:0] op, input logic [15:0] addr,
                                       input logic [7:0] data, input logic [18:0] mapped,
                                       input logic [1:0] kind, input logic irq,
                                       input logic mir);
        t_row r;
        r.acc = '{op, addr, data};
        r.typed = 1'b1;
        r.want = '{mapped, kind, irq, mir};
        return r;
    endfunction

    function automatic t_row row_model(input logic [2:0] op, input logic [15:0] addr,
                                       input logic [7:0] data);
        t_row r;
        r.acc = '{op, addr, data};
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Random access, weighted toward mapped reads, register writes and ticks
    function automatic t_access pick_access();
        t_access     a;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        a.addr = 16'($urandom);
        a.data = 8'($urandom);
        a.op = bmsi_pkg::OP_CPU_WR;
        if (sel < 22) begin
            a.op = bmsi_pkg::OP_CPU_RD;
            if ($urandom_range(0, 3) != 0) a.addr[15] = 1'b1;
        end else if (sel < 36) begin
            a.op = bmsi_pkg::OP_PPU_RD;
            if ($urandom_range(0, 3) != 0) a.addr[15:13] = 3'b000;
        end else if (sel < 46) begin
            a.addr[15:13] = {1'b1, bmsi_pkg::WIN_BANK};
            a.addr[0] = 1'b0;
        end else if (sel < 60) begin
            a.addr[15:13] = {1'b1, bmsi_pkg::WIN_BANK};
            a.addr[0] = 1'b1;
        end else if (sel < 72) begin
            a.addr[15] = 1'b1;
            a.addr[14:13] = 2'($urandom_range(bmsi_pkg::WIN_MIRROR, bmsi_pkg::WIN_ENABLE));
            // short reload values so the counter actually hits zero
            if (a.addr[14:13] == bmsi_pkg::WIN_LATCH && $urandom_range(0, 1) != 0) begin
                a.data = 8'($urandom_range(0, 4));
            end
        end else if (sel < 88) begin
            a.op = bmsi_pkg::OP_TICK;
        end else if (sel < 94) begin
            a.op = bmsi_pkg::OP_CPU_WR;
        end else if (sel < 97) begin
            a.op = bmsi_pkg::OP_PPU_WR;
        end else begin
            a.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        return a;
    endfunction

    // Present one beat; returns at the falling edge after it was taken, valid still high
    task automatic send_access(input t_access a, input logic typed, input t_mapping want);
        int       gap;
        t_mapping got;
        gap = draw_wait();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= a.op;
        req_ch.addr  <= a.addr;
        req_ch.data  <= a.data;
        do @(posedge clk); while (!req_ch.ready);
        got = map_access(a);
        mapping_q.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    task automatic write_bank_count(input logic reg_idx, input logic [5:0] count);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {26'($urandom), count};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_idx == bmsi_pkg::REG_PRG_CNT) begin
            cfg_prg = count;
        end else begin
            cfg_chr = count;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (mapping_q.size() != 0) @(negedge clk);
    endtask

    function automatic void check_field(input string what, input logic [18:0] want,
                                        input logic [18:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Result checker
    always @(posedge clk) begin
        t_mapping exp_m;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (mapping_q.size() == 0) begin
                $display("%0t: result with none expected, expected nothing got %0h/%0h",
                         $time, rsp_ch.map_offset, rsp_ch.target_kind);
                mismatches++;
            end else begin
                exp_m = mapping_q.pop_front();
                check_field("map_offset", exp_m.map_offset, rsp_ch.map_offset);
                check_field("target_kind", 19'(exp_m.target_kind), 19'(rsp_ch.target_kind));
                check_field("irq_line", 19'(exp_m.irq_line), 19'(rsp_ch.irq_line));
                check_field("mirror_horizontal", 19'(exp_m.mirror_horizontal),
                            19'(rsp_ch.mirror_horizontal));
            end
        end
    end

    // Watchdog on cycles with no beat and no register access
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result receiver with random back-pressure
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    // Stimulus
    initial begin
        int         ph;
        int         n;
        int         i;
        logic [5:0] prg_cnt;
        logic [5:0] chr_cnt;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.op    = bmsi_pkg::OP_CPU_RD;
        req_ch.addr  = '0;
        req_ch.data  = '0;

        // expected state after reset
        cfg_prg = bmsi_pkg::PRG_CNT_RESET;
        cfg_chr = bmsi_pkg::CHR_CNT_RESET;
        for (i = 0; i < 8; i++) begin
            bank_regs[i] = '0;
            chr_slot[i]  = '0;
        end
        bank_sel    = '0;
        prg_swap    = 1'b0;
        chr_swap    = 1'b0;
        mirror_h    = 1'b1;
        irq_reload  = '0;
        irq_down    = '0;
        irq_armed   = 1'b0;
        irq_flag    = 1'b0;
        prg_slot[0] = 6'd0;
        prg_slot[1] = 6'd1;
        prg_slot[2] = 6'd2;
        prg_slot[3] = 6'd3;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unmapped, ram and reset-slot mappings
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_RD, 16'h0000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_RD, 16'h5FFF, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_RD, 16'h6000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_PRG_RAM, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'h7FFF, 8'hFF, 19'h1FFF,
                                       bmsi_pkg::KIND_PRG_RAM, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_RD, 16'h8000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_PRG_ROM, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_RD, 16'hA001, 8'h00, 19'h2001,
                                       bmsi_pkg::KIND_PRG_ROM, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_RD, 16'hC123, 8'h00, 19'h4123,
                                       bmsi_pkg::KIND_PRG_ROM, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_RD, 16'hFFFF, 8'h00, 19'h7FFF,
                                       bmsi_pkg::KIND_PRG_ROM, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_PPU_RD, 16'h1FFF, 8'h00, 19'h3FF,
                                       bmsi_pkg::KIND_CHR_ROM, 0, 1));
        stim_table.push_back(row_typed(bmsi_pkg::OP_PPU_RD, 16'hFFFF, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 1));
        // ignored ops
        stim_table.push_back(row_typed(bmsi_pkg::OP_PPU_WR, 16'h0123, 8'hAA, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 1));
        stim_table.push_back(row_typed(OP_SPARE_LO, 16'h8000, 8'hFF, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 1));
        stim_table.push_back(row_typed(OP_SPARE_HI, 16'h1FFF, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 1));
        // mirroring; the odd address is ignored
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'hA000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'hA001, 8'h01, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        // select bank 7 with both mode bits, then a bank-data write
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'h8000, 8'hC7, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'h8001, 8'hFF, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_model(bmsi_pkg::OP_CPU_RD, 16'hA000, 8'h00));
        stim_table.push_back(row_model(bmsi_pkg::OP_CPU_RD, 16'h8000, 8'h00));
        stim_table.push_back(row_model(bmsi_pkg::OP_PPU_RD, 16'h0000, 8'h00));
        // scanline counter: latch 2, clear, enable, three ticks, disable
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'hC000, 8'h02, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'hC001, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'hE001, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_TICK, 16'h0000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_TICK, 16'h0000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_TICK, 16'h0000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 1, 0));
        stim_table.push_back(row_typed(bmsi_pkg::OP_CPU_WR, 16'hE000, 8'h00, 19'h0,
                                       bmsi_pkg::KIND_NONE, 0, 0));

        foreach (stim_table[k]) begin
            send_access(stim_table[k].acc, stim_table[k].typed, stim_table[k].want);
        end

        // Random phases, each under new bank counts; the sender holds off until
        // every result is back before touching the registers
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            req_ch.valid <= 1'b0;
            wait_drained();
            case (ph)
                0: begin prg_cnt = 6'd0;  chr_cnt = 6'd0;  end
                1: begin prg_cnt = 6'd32; chr_cnt = 6'd32; end
                2: begin prg_cnt = 6'd63; chr_cnt = 6'd40; end
                3: begin prg_cnt = 6'd1;  chr_cnt = 6'd1;  end
                4: begin prg_cnt = 6'd5;  chr_cnt = 6'd3;  end
                5: begin
                    prg_cnt = 6'($urandom_range(0, 63));
                    chr_cnt = 6'($urandom_range(0, 63));
                end
                6: begin prg_cnt = 6'd33; chr_cnt = 6'd63; end
                default: begin
                    prg_cnt = bmsi_pkg::PRG_CNT_RESET;
                    chr_cnt = bmsi_pkg::CHR_CNT_RESET;
                end
            endcase
            write_bank_count(bmsi_pkg::REG_PRG_CNT, prg_cnt);
            write_bank_count(bmsi_pkg::REG_CHR_CNT, chr_cnt);
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                // now and then a stretch with no idling on either side
                if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
                send_access(pick_access(), 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
